@@ design/polyline_stroke_expander_macros.svh @@
// ----------------------------------------------------------------------------
// polyline stroke expander assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef POLYLINE_STROKE_EXPANDER_MACROS_SVH
`define POLYLINE_STROKE_EXPANDER_MACROS_SVH

// same-cycle implication, off during reset
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also live during reset
`define PSE_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg
// types, register map and defaults shared by the stroke expander modules
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 24;
    localparam int INDEX_BITS_DEF = 16;

    // config register map (word index)
    localparam int          ADDR_BITS = 4;
    localparam logic [1:0]  REG_WIDTH = 2'd0;
    localparam logic [1:0]  REG_CLOSE = 2'd1;
    localparam logic [1:0]  REG_COLOR = 2'd2;

    // config reset values
    localparam logic [15:0] WIDTH_RST = 16'd256;
    localparam logic [31:0] COLOR_RST = 32'hFFFF_FFFF;

    // signed width of a corner offset (magnitude up to 2^15)
    localparam int OW = 18;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_SETUP = 4'd1,
        ST_NORM  = 4'd2,
        ST_ROOT  = 4'd3,
        ST_XGO   = 4'd4,
        ST_DIVX  = 4'd5,
        ST_YGO   = 4'd6,
        ST_DIVY  = 4'd7,
        ST_EMIT  = 4'd8
    } t_state;

    // shared unit states and operations
    typedef enum logic [1:0] {
        U_IDLE,
        U_PROD,
        U_SUM,
        U_ITER
    } t_ustate;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } t_op;

    // command into the shared unit
    typedef struct packed {
        logic        start;
        t_op         op;
        logic [30:0] a;
        logic [30:0] b;
        logic [15:0] w;
        logic [31:0] l;
    } t_ucmd;

    // answer from the shared unit
    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_ures;

endpackage

`default_nettype wire

@@ design/pse_unit.sv @@
// ----------------------------------------------------------------------------
// pse_unit
// shared multiplier and compare/subtract datapath: integer square root of
// a^2 + b^2 and the rounded quotient (a*w + l) / (2*l), one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pse_unit (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  pse_pkg::t_ucmd   i_cmd,
    output pse_pkg::t_ures   o_res
);
    import pse_pkg::*;

    t_ustate     r_st, n_st;
    t_op         r_op;
    logic [30:0] r_b;
    logic [31:0] r_l;
    logic [63:0] r_p;
    logic [63:0] r_acc;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic [63:0] r_dsh;
    logic [15:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_done;

    logic [31:0] m_a, m_b;
    logic [63:0] prod;
    logic [63:0] rhs;
    logic [64:0] diff;
    logic        ge;

    // shared multiplier operand select
    always_comb begin
        if (r_st == U_IDLE) begin
            m_a = {1'b0, i_cmd.a};
            m_b = (i_cmd.op == OP_SQRT) ? {1'b0, i_cmd.a} : {16'd0, i_cmd.w};
        end else begin
            m_a = {1'b0, r_b};
            m_b = {1'b0, r_b};
        end
    end
    assign prod = m_a * m_b;

    // shared compare and subtract
    assign rhs  = (r_op == OP_SQRT) ? (r_root + r_bit) : r_dsh;
    assign diff = {1'b0, r_acc} - {1'b0, rhs};
    assign ge   = ~diff[64];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == U_ITER) && (r_cnt == 6'd1);
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            U_IDLE: begin
                if (i_cmd.start) n_st = U_PROD;
            end
            U_PROD: begin
                n_st = (r_op == OP_SQRT) ? U_SUM : U_ITER;
            end
            U_SUM: begin
                n_st = U_ITER;
            end
            U_ITER: begin
                if (r_cnt == 6'd1) n_st = U_IDLE;
            end
            default: n_st = U_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_p <= prod;
        case (r_st)
            U_IDLE: begin
                if (i_cmd.start) begin
                    r_op <= i_cmd.op;
                    r_b  <= i_cmd.b;
                    r_l  <= i_cmd.l;
                end
            end
            U_PROD: begin
                if (r_op == OP_SQRT) begin
                    r_acc <= r_p;
                end else begin
                    r_acc <= r_p + {32'd0, r_l};
                    r_dsh <= {16'd0, r_l, 16'd0};
                    r_q   <= '0;
                    r_cnt <= 6'd16;
                end
            end
            U_SUM: begin
                r_acc  <= r_acc + r_p;
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_cnt  <= 6'd32;
            end
            U_ITER: begin
                if (ge) r_acc <= diff[63:0];
                if (r_op == OP_SQRT) begin
                    r_root <= ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
                    r_bit  <= r_bit >> 2;
                end else begin
                    r_q   <= {r_q[14:0], ge};
                    r_dsh <= r_dsh >> 1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.res  = (r_op == OP_SQRT) ? r_root[31:0] : {16'd0, r_q};

endmodule

`default_nettype wire

@@ design/polyline_stroke_expander.sv @@
// ----------------------------------------------------------------------------
// polyline_stroke_expander
// turns a stream of polyline points into four-vertex quads per segment
//
//  channel  | dir | beat contents
//  s_axis   | in  | tdata: point_x, point_y; tlast: end_of_path
//  m_axis   | out | tdata: vert_x, vert_y, vert_color, vert_number;
//           |     | tuser: quad_corner; tlast: run_last
//  apb      | in  | stroke_width @0x0, close_loop @0x4, stroke_color @0x8
//
// the first point of a path is only stored; an axis-aligned segment goes from
// setup straight to its 4 vertex beats; an inclined segment first normalizes,
// then takes the root and two quotients, all on the one shared multiply/subtract
// unit, then its 4 vertex beats; a closing segment repeats that segment work;
// input ready only while idle; synchronous active-low reset; output register
// holds a beat under stall
`default_nettype none

module polyline_stroke_expander #(
    parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = pse_pkg::INDEX_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // point stream
    input  wire                                    i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // point_x, point_y
    input  wire  [((2*COORD_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    input  wire                                    i_s_axis_tlast,
    // vertex stream
    output logic                                   o_m_axis_tvalid,
    input  wire                                    i_m_axis_tready,
    // vert_x, vert_y, vert_color, vert_number
    output logic [((2*COORD_BITS+48+7)/8)*8-1:0]   o_m_axis_tdata,
    // quad_corner
    output logic [1:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tlast,
    // config
    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [pse_pkg::ADDR_BITS-1:0]          paddr,
    input  wire  [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import pse_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int DW     = C + 1;
    localparam int AW     = (DW > 31) ? DW : 31;
    localparam int SW     = ((C > OW) ? C : OW) + 2;
    localparam int OUT_TW = ((2*C+48+7)/8)*8;

    t_state r_state, n_state;

    // config
    logic [15:0] r_wid;
    logic        r_close;
    logic [31:0] r_color;

    // path state
    logic [C-1:0] r_sx, r_sy, r_px, r_py;
    logic         r_have;
    logic [INDEX_BITS-1:0] r_vcnt;

    // segment work
    logic [C-1:0] r_ex0, r_ey0, r_ex1, r_ey1;
    logic [C-1:0] r_p0x, r_p0y, r_p1x, r_p1y;
    logic         r_last_in, r_first;
    logic         r_negx, r_negy;
    logic [AW-1:0] r_ax, r_ay;
    logic [31:0]  r_len;
    logic [15:0]  r_xm;
    logic signed [OW-1:0] r_o0x, r_o0y, r_o1x, r_o1y;
    logic [1:0]   r_corner;

    // output register
    logic              r_ovalid;
    logic [C-1:0]      r_vx, r_vy;
    logic [31:0]       r_vcol;
    logic [15:0]       r_vnum;
    logic [1:0]        r_vcor;
    logic              r_vlast;

    t_ucmd ucmd;
    t_ures ures;

    logic s_acc, cfg_wr, out_load, big, close_now;
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0] dxa, dya;
    logic swap;
    logic [16:0] wid1;
    logic signed [OW-1:0] hs, hfx, hfy;
    logic signed [OW-1:0] xf, yf;
    logic [C-1:0] bx, by;
    logic signed [OW-1:0] offx, offy;
    logic signed [SW-1:0] sumx, sumy, sat_hi, sat_lo;
    logic [C-1:0] vx, vy;
    logic [INDEX_BITS-1:0] vnum;
    logic [31:0] vnum32;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (r_state == ST_EMIT) && (!r_ovalid || i_m_axis_tready);
    assign close_now = r_first && r_last_in && r_close;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign pready          = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid   <= WIDTH_RST;
            r_close <= 1'b0;
            r_color <= COLOR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH: r_wid   <= pwdata[15:0];
                REG_CLOSE: r_close <= pwdata[0];
                REG_COLOR: r_color <= pwdata;
                default: ;
            endcase
        end
    end

    // config readback
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH: prdata = {16'd0, r_wid};
            REG_CLOSE: prdata = {31'd0, r_close};
            REG_COLOR: prdata = r_color;
            default:   prdata = '0;
        endcase
    end

    // segment deltas, swap and axis offsets
    assign dx   = $signed({r_ex1[C-1], r_ex1}) - $signed({r_ex0[C-1], r_ex0});
    assign dy   = $signed({r_ey1[C-1], r_ey1}) - $signed({r_ey0[C-1], r_ey0});
    assign dxa  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign dya  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign swap = dx[DW-1] || dy[DW-1] || ((dx != '0) && (dy != '0));
    assign wid1 = {1'b0, r_wid} + 17'd1;
    assign hs   = $signed({{(OW-16){1'b0}}, wid1[16:1]});
    assign hfx  = (!dx[DW-1] && (dx != '0)) ? hs : -hs;
    assign hfy  = (!dy[DW-1] && (dy != '0)) ? hs : -hs;
    assign big  = ((r_ax >> 31) != '0) || ((r_ay >> 31) != '0);

    // signed normal offsets from the quotients
    assign xf = r_negx ? -$signed({2'b00, r_xm}) : $signed({2'b00, r_xm});
    assign yf = r_negy ? -$signed({2'b00, ures.res[15:0]}) : $signed({2'b00, ures.res[15:0]});

    // shared unit commands
    always_comb begin
        ucmd.start = ((r_state == ST_NORM) && !big) || (r_state == ST_XGO) ||
                     (r_state == ST_YGO);
        ucmd.op    = (r_state == ST_NORM) ? OP_SQRT : OP_DIV;
        ucmd.a     = (r_state == ST_YGO) ? r_ay[30:0] : r_ax[30:0];
        ucmd.b     = r_ay[30:0];
        ucmd.w     = r_wid;
        ucmd.l     = r_len;
    end

    pse_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ucmd),
        .o_res   (ures)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_acc && r_have) n_state = ST_SETUP;
            ST_SETUP: n_state = ((dy == '0) || (dx == '0)) ? ST_EMIT : ST_NORM;
            ST_NORM:  if (!big) n_state = ST_ROOT;
            ST_ROOT:  if (ures.done) n_state = ST_XGO;
            ST_XGO:   n_state = ST_DIVX;
            ST_DIVX:  if (ures.done) n_state = ST_YGO;
            ST_YGO:   n_state = ST_DIVY;
            ST_DIVY:  if (ures.done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_load && (r_corner == 2'd3))
                    n_state = close_now ? ST_SETUP : ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // path and segment registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx   <= '0;
            r_sy   <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_have <= 1'b0;
            r_vcnt <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (!r_have) begin
                            r_sx   <= i_s_axis_tdata[C-1:0];
                            r_sy   <= i_s_axis_tdata[2*C-1:C];
                            r_px   <= i_s_axis_tdata[C-1:0];
                            r_py   <= i_s_axis_tdata[2*C-1:C];
                            r_have <= !i_s_axis_tlast;
                        end else begin
                            r_ex0     <= r_px;
                            r_ey0     <= r_py;
                            r_ex1     <= i_s_axis_tdata[C-1:0];
                            r_ey1     <= i_s_axis_tdata[2*C-1:C];
                            r_last_in <= i_s_axis_tlast;
                            r_first   <= 1'b1;
                        end
                    end
                end
                ST_SETUP: begin
                    r_p0x    <= swap ? r_ex1 : r_ex0;
                    r_p0y    <= swap ? r_ey1 : r_ey0;
                    r_p1x    <= swap ? r_ex0 : r_ex1;
                    r_p1y    <= swap ? r_ey0 : r_ey1;
                    r_negx   <= dx[DW-1];
                    r_negy   <= dy[DW-1];
                    r_ax     <= AW'(dxa);
                    r_ay     <= AW'(dya);
                    r_corner <= 2'd0;
                    if (dy == '0) begin
                        r_o0x <= -hfx;
                        r_o0y <= -hs;
                        r_o1x <= hfx;
                        r_o1y <= -hs;
                    end else if (dx == '0) begin
                        r_o0x <= hs;
                        r_o0y <= -hfy;
                        r_o1x <= hs;
                        r_o1y <= hfy;
                    end
                end
                ST_NORM: begin
                    if (big) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end
                end
                ST_ROOT: begin
                    if (ures.done) r_len <= (ures.res == '0) ? 32'd1 : ures.res;
                end
                ST_DIVX: begin
                    if (ures.done) r_xm <= ures.res[15:0];
                end
                ST_DIVY: begin
                    if (ures.done) begin
                        r_o0x <= -yf;
                        r_o0y <= xf;
                        r_o1x <= -yf;
                        r_o1y <= xf;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_corner <= r_corner + 2'd1;
                        if (r_corner == 2'd3) begin
                            r_vcnt <= r_vcnt + INDEX_BITS'(4);
                            if (r_first) begin
                                r_px <= r_ex1;
                                r_py <= r_ey1;
                                if (r_last_in) r_have <= 1'b0;
                            end
                            // closing segment runs from this point back to start
                            r_ex0   <= r_ex1;
                            r_ey0   <= r_ey1;
                            r_ex1   <= r_sx;
                            r_ey1   <= r_sy;
                            r_first <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // corner vertex: pick endpoint and offset, add and saturate
    always_comb begin
        bx = ((r_corner == 2'd0) || (r_corner == 2'd3)) ? r_p0x : r_p1x;
        by = ((r_corner == 2'd0) || (r_corner == 2'd3)) ? r_p0y : r_p1y;
        case (r_corner)
            2'd0:    begin offx = r_o0x;  offy = r_o0y;  end
            2'd1:    begin offx = r_o1x;  offy = r_o1y;  end
            2'd2:    begin offx = -r_o0x; offy = -r_o0y; end
            default: begin offx = -r_o1x; offy = -r_o1y; end
        endcase
        sumx   = $signed({{(SW-C){bx[C-1]}}, bx}) + $signed({{(SW-OW){offx[OW-1]}}, offx});
        sumy   = $signed({{(SW-C){by[C-1]}}, by}) + $signed({{(SW-OW){offy[OW-1]}}, offy});
        sat_hi = $signed({{(SW-C){1'b0}}, 1'b0, {(C-1){1'b1}}});
        sat_lo = ~sat_hi;
        if (sumx > sat_hi)      vx = sat_hi[C-1:0];
        else if (sumx < sat_lo) vx = sat_lo[C-1:0];
        else                    vx = sumx[C-1:0];
        if (sumy > sat_hi)      vy = sat_hi[C-1:0];
        else if (sumy < sat_lo) vy = sat_lo[C-1:0];
        else                    vy = sumy[C-1:0];
        vnum   = r_vcnt + INDEX_BITS'(r_corner);
        vnum32 = 32'(vnum);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)             r_ovalid <= 1'b0;
        else if (out_load)        r_ovalid <= 1'b1;
        else if (i_m_axis_tready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_vx    <= vx;
            r_vy    <= vy;
            r_vcol  <= r_color;
            r_vnum  <= vnum32[15:0];
            r_vcor  <= r_corner;
            r_vlast <= (r_corner == 2'd3) && !close_now;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TW'({r_vnum, r_vcol, r_vy, r_vx});
    assign o_m_axis_tuser  = r_vcor;
    assign o_m_axis_tlast  = r_vlast;

endmodule

`default_nettype wire

@@ design/pse_checker.sv @@
// ----------------------------------------------------------------------------
// pse_checker
// port-level checks for the stroke expander, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_stroke_expander_macros.svh"

module pse_checker #(
    parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  o_s_axis_tready,
    input wire                                  o_m_axis_tvalid,
    input wire                                  i_m_axis_tready,
    input wire [((2*COORD_BITS+48+7)/8)*8-1:0]  o_m_axis_tdata,
    input wire [1:0]                            o_m_axis_tuser,
    input wire                                  o_m_axis_tlast
);

    // a stalled vertex beat holds
    `PSE_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled vertex beat changed")

    // run end only on the fourth corner
    `PSE_ASSERT_NOW(a_last_corner, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser == 2'd3, "run end on a corner other than three")

    // a new point is taken only after a whole quad was loaded for output
    `PSE_ASSERT_NOW(a_ready_quad, o_s_axis_tready && o_m_axis_tvalid, o_m_axis_tuser == 2'd3, "input ready while a quad is unfinished")

    // reset empties the output
    `PSE_ASSERT_NEXT_ALWAYS(a_rst, !i_rst_n, !o_m_axis_tvalid, "vertex valid after reset")

endmodule

bind polyline_stroke_expander pse_checker #(.COORD_BITS(COORD_BITS)) u_pse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
